[rtl/svb_pkg.sv]
// ============================================================================
// svb_pkg: shared types, constants and helpers
// Sizes, operation codes and saturation functions for the skinned vertex blend.
// ============================================================================
package svb_pkg;

    localparam int JOINTS     = 64;
    localparam int INFLUENCES = 8;
    localparam int ELEMS      = 12;

    localparam int ADDR_W  = $clog2(JOINTS * ELEMS);
    localparam int CNT_W   = $clog2(INFLUENCES + 1);
    localparam int ELEM_W  = 4;

    localparam logic [15:0] WEIGHT_ONE    = 16'd32768;
    localparam logic [15:0] VIS_MIN_RESET = 16'd32736;

    localparam logic OP_WRITE     = 1'b0;
    localparam logic OP_INFLUENCE = 1'b1;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic              capture;     // latch the accepted request
        logic              mem_we;      // write one palette element
        logic              mem_re;      // read palette element elem
        logic              load_prod;   // element times coordinate, or translation
        logic              acc_row;     // add product into the row sum
        logic              clr_row;     // zero the row sum
        logic              wmul;        // row times weight
        logic              wacc;        // add weighted row into its sum
        logic              count_inc;   // take one influence slot
        logic              vis_acc;     // add weight to vis sum if 3x3 block non-zero
        logic              load_out;    // load the result register
        logic              clr_vertex;  // drop the vertex state
        logic [ELEM_W-1:0] elem;        // palette element in work
    } svb_cmd_t;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic is_write;
        logic last;
        logic count_full;
        logic active;      // weight non-zero and joint in range
    } svb_stat_t;

    // Saturate a 51-bit signed value to 48 bits
    function automatic logic signed [47:0] sat48(input logic signed [50:0] v);
        logic signed [47:0] r;
        if ((v[50:47] == 4'b0000) || (v[50:47] == 4'b1111))
            r = v[47:0];
        else if (v[50])
            r = {1'b1, 47'b0};
        else
            r = {1'b0, {47{1'b1}}};
        return r;
    endfunction

    // Saturate a 48-bit signed value to 32 bits; top bit flags a clamp
    function automatic logic [32:0] sat32(input logic signed [47:0] v);
        logic [32:0] r;
        if ((v[47:31] == '0) || (v[47:31] == '1))
            r = {1'b0, v[31:0]};
        else if (v[47])
            r = {1'b1, 1'b1, 31'b0};
        else
            r = {1'b1, 1'b0, {31{1'b1}}};
        return r;
    endfunction

endpackage

[rtl/svb_ctrl.sv]
// ============================================================================
// svb_ctrl: request sequencer
// Steps a request: decode, twelve palette reads if active, then the emit.
// ============================================================================
module svb_ctrl
    import svb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  svb_stat_t stat,
    output svb_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_RD     = 4'd2;
    localparam logic [3:0] S_MUL    = 4'd3;
    localparam logic [3:0] S_ACC    = 4'd4;
    localparam logic [3:0] S_WMUL   = 4'd5;
    localparam logic [3:0] S_WACC   = 4'd6;
    localparam logic [3:0] S_VIS    = 4'd7;
    localparam logic [3:0] S_LAST   = 4'd8;

    localparam logic [ELEM_W-1:0] ELEM_LAST = ELEM_W'(ELEMS - 1);

    logic [3:0]        state_reg, state_next;
    logic [ELEM_W-1:0] elem_reg, elem_next;
    logic              out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        elem_next  = elem_reg;
        cmd        = '0;
        cmd.elem   = elem_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.is_write)
                begin
                    cmd.mem_we = 1'b1;
                    state_next = S_IDLE;
                end
                else if (stat.count_full)
                    state_next = S_LAST;
                else
                begin
                    cmd.count_inc = 1'b1;
                    if (stat.active)
                    begin
                        cmd.clr_row = 1'b1;
                        elem_next   = '0;
                        state_next  = S_RD;
                    end
                    else
                        state_next = S_LAST;
                end
            end
            S_RD:
            begin
                cmd.mem_re = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.load_prod = 1'b1;
                state_next    = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_row = 1'b1;
                if (elem_reg[1:0] == 2'd3)
                    state_next = S_WMUL;
                else
                begin
                    elem_next  = elem_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_WMUL:
            begin
                cmd.wmul   = 1'b1;
                state_next = S_WACC;
            end
            S_WACC:
            begin
                cmd.wacc    = 1'b1;
                cmd.clr_row = 1'b1;
                if (elem_reg == ELEM_LAST)
                    state_next = S_VIS;
                else
                begin
                    elem_next  = elem_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_VIS:
            begin
                cmd.vis_acc = 1'b1;
                state_next  = S_LAST;
            end
            S_LAST:
            begin
                if (!stat.last)
                    state_next = S_IDLE;
                else if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.clr_vertex = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            elem_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            elem_reg      <= elem_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[rtl/svb_datapath.sv]
// ============================================================================
// svb_datapath: palette memory, multipliers and vertex sums
// Holds the request, the palette, the row and vertex sums and the result.
// ============================================================================
module svb_datapath
    import svb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  svb_cmd_t           cmd,
    output svb_stat_t          stat,
    input  logic [15:0]        vis_min,
    input  logic               operation,
    input  logic [5:0]         joint,
    input  logic [3:0]         element,
    input  logic signed [31:0] matrix_value,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic [15:0]        weight,
    input  logic               last_influence,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic               visible
);

    // Captured request
    logic               op_reg;
    logic [5:0]         joint_reg;
    logic [3:0]         element_reg;
    logic signed [31:0] value_reg;
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic [15:0]        weight_reg;
    logic               last_reg;

    // Palette
    logic [31:0]        palette_mem [JOINTS * ELEMS];
    logic signed [31:0] rdata_reg;
    logic [ADDR_W-1:0]  wr_addr, rd_addr;
    logic               joint_ok, element_ok;

    // Arithmetic
    logic signed [31:0] pos_sel;
    logic signed [63:0] prod_next;
    logic signed [63:0] prod_reg;
    logic signed [47:0] prod_hi;
    logic signed [49:0] row_reg;
    logic signed [47:0] row_sat;
    logic signed [16:0] weight_s;
    logic signed [64:0] wprod_next, wprod_reg;
    logic signed [49:0] wshift;
    logic signed [47:0] sum_cur, sum_new;
    logic signed [47:0] sum_x_reg, sum_y_reg, sum_z_reg;
    logic [18:0]        vsum_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               nonzero_reg;
    logic [32:0]        sx, sy, sz;

    assign joint_ok   = 32'(joint_reg) < JOINTS;
    assign element_ok = 32'(element_reg) < ELEMS;
    assign wr_addr    = ADDR_W'(32'(joint_reg) * ELEMS + 32'(element_reg));
    assign rd_addr    = ADDR_W'(32'(joint_reg) * ELEMS + 32'(cmd.elem));

    assign stat.is_write   = (op_reg == OP_WRITE);
    assign stat.last       = last_reg;
    assign stat.count_full = 32'(count_reg) >= INFLUENCES;
    assign stat.active     = (weight_reg != '0) && joint_ok;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg      <= operation;
            joint_reg   <= joint;
            element_reg <= element;
            value_reg   <= matrix_value;
            px_reg      <= pos_x;
            py_reg      <= pos_y;
            pz_reg      <= pos_z;
            weight_reg  <= (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
            last_reg    <= last_influence;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_we && joint_ok && element_ok)
            palette_mem[wr_addr] <= value_reg;
        if (cmd.mem_re)
            rdata_reg <= palette_mem[rd_addr];
    end

    // Coordinate for the column in work; the fourth column is translation
    always_comb
    begin
        unique case (cmd.elem[1:0])
            2'd0:    pos_sel = px_reg;
            2'd1:    pos_sel = py_reg;
            2'd2:    pos_sel = pz_reg;
            default: pos_sel = '0;
        endcase
    end

    always_comb
    begin
        if (cmd.elem[1:0] == 2'd3)
            prod_next = {{16{rdata_reg[31]}}, rdata_reg, 16'b0};
        else
            prod_next = rdata_reg * pos_sel;
    end

    assign prod_hi    = prod_reg[63:16];
    assign row_sat    = sat48(51'(row_reg));
    assign weight_s   = {1'b0, weight_reg};
    assign wprod_next = row_sat * weight_s;
    assign wshift     = wprod_reg[64:15];

    always_comb
    begin
        unique case (cmd.elem[3:2])
            2'd0:    sum_cur = sum_x_reg;
            2'd1:    sum_cur = sum_y_reg;
            default: sum_cur = sum_z_reg;
        endcase
    end

    assign sum_new = sat48(51'(sum_cur) + 51'(wshift));

    always_ff @(posedge clk)
    begin
        if (cmd.load_prod)
            prod_reg <= prod_next;
        if (cmd.wmul)
            wprod_reg <= wprod_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg     <= '0;
            nonzero_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_row)
                row_reg <= '0;
            else if (cmd.acc_row)
                row_reg <= row_reg + 50'(prod_hi);
            if (cmd.count_inc)
                nonzero_reg <= 1'b0;
            else if (cmd.load_prod && (cmd.elem[1:0] != 2'd3) && (rdata_reg != '0))
                nonzero_reg <= 1'b1;
        end
    end

    // Vertex state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            sum_z_reg <= '0;
            vsum_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.clr_vertex)
        begin
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            sum_z_reg <= '0;
            vsum_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.count_inc)
                count_reg <= count_reg + 1'b1;
            if (cmd.vis_acc && nonzero_reg)
                vsum_reg <= vsum_reg + 19'(weight_reg);
            if (cmd.wacc)
            begin
                unique case (cmd.elem[3:2])
                    2'd0:    sum_x_reg <= sum_new;
                    2'd1:    sum_y_reg <= sum_new;
                    default: sum_z_reg <= sum_new;
                endcase
            end
        end
    end

    // Result register
    assign sx = sat32(sum_x_reg);
    assign sy = sat32(sum_y_reg);
    assign sz = sat32(sum_z_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_x   <= sx[31:0];
            out_y   <= sy[31:0];
            out_z   <= sz[31:0];
            visible <= !(sx[32] || sy[32] || sz[32]) && (vsum_reg >= 19'(vis_min));
        end
    end

endmodule

[rtl/skinned_vertex_blend_top.sv]
// ============================================================================
// skinned_vertex_blend_top: fixed-point linear blend skinning
// Palette of affine Q16.16 matrices, weighted accumulation of transformed
// positions per vertex, saturated result with a visibility flag.
// ============================================================================
//
//  channel  handshake              payload
//  -------  ---------------------  ------------------------------------------
//  in       in_valid / in_ready    operation, joint, element, matrix_value,
//                                  pos_x, pos_y, pos_z, weight, last_influence
//  out      out_valid / out_ready  out_x, out_y, out_z, visible
//  cfg      cfg_valid / cfg_ready  visible_weight_min
//
//  A palette write is stored in the decode step. An influence that uses a
//  matrix reads, multiplies and accumulates each of the twelve elements in
//  turn, plus weighting per row. An influence skipped (zero weight, slots
//  used up, joint out of range) goes from decode straight to the close. A
//  closing influence waits only while the result register still holds an
//  untaken result. Reset clears the sums and the counters; the palette
//  holds nothing defined until written. cfg is always ready.
//
module skinned_vertex_blend_top
    import svb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // input requests
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               operation,
    input  logic [5:0]         joint,
    input  logic [3:0]         element,
    input  logic signed [31:0] matrix_value,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic [15:0]        weight,
    input  logic               last_influence,
    // results
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic               visible,
    // configuration
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        visible_weight_min
);

    svb_cmd_t    cmd;
    svb_stat_t   stat;
    logic [15:0] vis_min_reg, vis_min_next;

    // Take configuration writes at any time; the block is idle by contract
    assign cfg_ready    = 1'b1;
    assign vis_min_next = (cfg_valid && cfg_ready) ? visible_weight_min : vis_min_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vis_min_reg <= VIS_MIN_RESET;
        else
            vis_min_reg <= vis_min_next;
    end

    // Sequencer: one request at a time, hold results until taken
    svb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: palette, multipliers, sums and result register
    svb_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .vis_min        (vis_min_reg),
        .operation      (operation),
        .joint          (joint),
        .element        (element),
        .matrix_value   (matrix_value),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .weight         (weight),
        .last_influence (last_influence),
        .out_x          (out_x),
        .out_y          (out_y),
        .out_z          (out_z),
        .visible        (visible)
    );

endmodule

[dv/skinned_vertex_blend_top_test.sv]
// ============================================================================
// skinned_vertex_blend_top_test: self-checking bench for the skinned blend
// Loads palette matrices, streams vertex influences with random pacing on
// both channels and checks every result against a bit-accurate blend model.
// ============================================================================
module skinned_vertex_blend_top_test;
    import svb_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int unsigned SETTLE      = 64;
    localparam int unsigned PHASES      = 6;
    localparam int unsigned PHASE_ITEMS = 325;

    localparam longint SUM_HI = 64'sh7FFF_FFFF_FFFF;
    localparam longint SUM_LO = -SUM_HI - 1;
    localparam longint I32_HI = 64'sd2147483647;
    localparam longint I32_LO = -I32_HI - 1;

    localparam logic signed [31:0] UNIT = 32'sd65536;   // 1.0 in Q16.16

    typedef enum int {M_IDENTITY, M_TRANSLATE, M_EXTREME, M_SMALL, M_SPARSE, M_WIDE}
        matrix_style_t;

    // One request on the input channel, as the block sees it
    typedef struct {
        logic               op;
        logic [5:0]         joint;
        logic [3:0]         elem;
        logic signed [31:0] mval;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic [15:0]        weight;
        logic               last;
    } blend_request_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               vis;
    } blend_result_t;

    // ------------------------------------------------------------------------
    // Blend model: own copy of the palette and the vertex sums, plus the queue
    // of blended positions still owed by the block.
    // ------------------------------------------------------------------------
    class blend_scoreboard;
        logic signed [31:0] palette [JOINTS*ELEMS];
        longint             acc [3];
        int unsigned        vis_sum;
        int unsigned        slots;
        logic [15:0]        vis_min;
        blend_result_t      owed_q [$];
        int unsigned        errors;

        function new();
            foreach (palette[i]) palette[i] = '0;
            clear_vertex();
            vis_min = VIS_MIN_RESET;
            errors  = 0;
        endfunction

        function void clear_vertex();
            acc[0]  = 0;
            acc[1]  = 0;
            acc[2]  = 0;
            vis_sum = 0;
            slots   = 0;
        endfunction

        function longint clamp48(longint v);
            if (v > SUM_HI)
                return SUM_HI;
            if (v < SUM_LO)
                return SUM_LO;
            return v;
        endfunction

        function void set_threshold(logic [15:0] v);
            vis_min = v;
        endfunction

        function int unsigned pending();
            return owed_q.size();
        endfunction

        // Fold one accepted request into the model
        function void note_request(blend_request_t rq);
            int unsigned        w;
            int unsigned        base;
            int unsigned        r;
            int unsigned        c;
            longint             row;
            longint             p [3];
            logic               spans;
            logic               clipped;
            logic signed [31:0] o [3];
            blend_result_t      res;
            base = rq.joint * ELEMS;
            if (rq.op == OP_WRITE)
            begin
                if (rq.elem < ELEMS)
                    palette[base + rq.elem] = rq.mval;
                return;
            end
            w = (rq.weight > WEIGHT_ONE) ? WEIGHT_ONE : rq.weight;
            // influences past the slot limit are dropped, but a last mark still closes
            if (slots < INFLUENCES)
            begin
                slots++;
                if (w != 0)
                begin
                    p[0]  = rq.px;
                    p[1]  = rq.py;
                    p[2]  = rq.pz;
                    spans = 1'b0;
                    for (r = 0; r < 3; r++)
                    begin
                        row = palette[base + r*4 + 3];
                        for (c = 0; c < 3; c++)
                        begin
                            row += (longint'(palette[base + r*4 + c]) * p[c]) >>> 16;
                            if (palette[base + r*4 + c] != 0)
                                spans = 1'b1;
                        end
                        row    = clamp48(row);
                        acc[r] = clamp48(acc[r] + ((row * longint'(w)) >>> 15));
                    end
                    if (spans)
                        vis_sum = (vis_sum + w) & 32'h7FFFF;
                end
            end
            if (!rq.last)
                return;
            clipped = 1'b0;
            for (r = 0; r < 3; r++)
            begin
                if (acc[r] > I32_HI)
                begin
                    o[r]    = 32'sh7FFF_FFFF;
                    clipped = 1'b1;
                end
                else if (acc[r] < I32_LO)
                begin
                    o[r]    = 32'sh8000_0000;
                    clipped = 1'b1;
                end
                else
                    o[r] = acc[r][31:0];
            end
            res.x   = o[0];
            res.y   = o[1];
            res.z   = o[2];
            res.vis = !clipped && (vis_sum >= vis_min);
            owed_q.insert(owed_q.size(), res);
            clear_vertex();
        endfunction

        // Compare one accepted result with the oldest owed position
        function void check_result(logic signed [31:0] x, logic signed [31:0] y,
                                   logic signed [31:0] z, logic vis);
            blend_result_t want;
            if (owed_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: x=%h y=%h z=%h visible=%b", x, y, z, vis);
                return;
            end
            want = owed_q.pop_front();
            if (x !== want.x || y !== want.y || z !== want.z || vis !== want.vis)
            begin
                errors++;
                if (errors <= 10)
                    $display({"result mismatch: want x=%h y=%h z=%h visible=%b, ",
                              "got x=%h y=%h z=%h visible=%b"},
                             want.x, want.y, want.z, want.vis, x, y, z, vis);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Bench signals and the block
    // ------------------------------------------------------------------------
    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               operation;
    logic [5:0]         joint;
    logic [3:0]         element;
    logic signed [31:0] matrix_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [15:0]        weight;
    logic               last_influence;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               visible;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [15:0]        visible_weight_min;

    blend_scoreboard    sb;
    logic [ELEMS-1:0]   loaded [JOINTS];   // palette elements written so far
    int unsigned        items_sent = 0;
    int unsigned        burst_left = 0;    // requests still to go with no gap
    int unsigned        cycles = 0;

    skinned_vertex_blend_top u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .operation          (operation),
        .joint              (joint),
        .element            (element),
        .matrix_value       (matrix_value),
        .pos_x              (pos_x),
        .pos_y              (pos_y),
        .pos_z              (pos_z),
        .weight             (weight),
        .last_influence     (last_influence),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .out_x              (out_x),
        .out_y              (out_y),
        .out_z              (out_z),
        .visible            (visible),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .visible_weight_min (visible_weight_min)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Give up on a hung block
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Check each result as it is taken; values sampled here are pre-edge
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
            sb.check_result(out_x, out_y, out_z, visible);
    end

    // ------------------------------------------------------------------------
    // Random pacing and value helpers
    // ------------------------------------------------------------------------

    // Mostly no gap or a short one, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic signed [31:0] rand_span(int unsigned half);
        return 32'(int'($urandom_range(0, 2 * half)) - int'(half));
    endfunction

    // Coordinate: mostly modest, some full range and the corner values
    function automatic logic signed [31:0] rand_coord();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return rand_span(32'd16777216);
        if (r < 80)
            return $urandom;
        if (r < 90)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'sh7FFF_FFFF;
                1:       return 32'sh8000_0000;
                2:       return -32'sd1;
                default: return '0;
            endcase
        end
        return rand_span(32'd65536);
    endfunction

    // Only joints with all twelve elements written may be read
    function automatic logic [5:0] pick_joint();
        logic [5:0] j;
        do
            j = 6'($urandom_range(0, JOINTS - 1));
        while (!(&loaded[j]));
        return j;
    endfunction

    function automatic blend_request_t make_write(logic [5:0] j, logic [3:0] e,
                                                  logic signed [31:0] v);
        blend_request_t rq;
        rq.op     = OP_WRITE;
        rq.joint  = j;
        rq.elem   = e;
        rq.mval   = v;
        rq.px     = $urandom;
        rq.py     = $urandom;
        rq.pz     = $urandom;
        rq.weight = 16'($urandom);
        rq.last   = 1'($urandom_range(0, 1));
        return rq;
    endfunction

    function automatic blend_request_t make_influence(logic [5:0] j, logic signed [31:0] px,
                                                      logic signed [31:0] py,
                                                      logic signed [31:0] pz,
                                                      logic [15:0] w, logic last);
        blend_request_t rq;
        rq.op     = OP_INFLUENCE;
        rq.joint  = j;
        rq.elem   = 4'($urandom);
        rq.mval   = $urandom;
        rq.px     = px;
        rq.py     = py;
        rq.pz     = pz;
        rq.weight = w;
        rq.last   = last;
        return rq;
    endfunction

    // ------------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------------

    // Present one request, hold it until taken, then note it in the model
    task automatic send_request(input blend_request_t rq);
        int unsigned gap;
        if (burst_left != 0)
        begin
            gap = 0;
            burst_left--;
        end
        else
        begin
            gap = pick_gap();
            if ($urandom_range(0, 99) < 3)
                burst_left = $urandom_range(20, 120);
        end
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        operation      <= rq.op;
        joint          <= rq.joint;
        element        <= rq.elem;
        matrix_value   <= rq.mval;
        pos_x          <= rq.px;
        pos_y          <= rq.py;
        pos_z          <= rq.pz;
        weight         <= rq.weight;
        last_influence <= rq.last;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        sb.note_request(rq);
        if (rq.op == OP_WRITE && rq.elem < ELEMS)
            loaded[rq.joint][rq.elem] = 1'b1;
        items_sent++;
    endtask

    // Drop valid and hold off until every owed result is back, then settle
    task automatic drain_results(input int unsigned settle);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [15:0] v);
        cfg_valid          <= 1'b1;
        visible_weight_min <= v;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        sb.set_threshold(v);
        cfg_valid <= 1'b0;
    endtask

    // Write a whole matrix of the given flavour, element by element
    task automatic load_matrix(input logic [5:0] j, input matrix_style_t style);
        logic signed [31:0] v;
        int unsigned        e;
        for (e = 0; e < ELEMS; e++)
        begin
            case (style)
                M_IDENTITY:  v = (e % 4 == e / 4) ? UNIT : '0;
                M_TRANSLATE: v = (e % 4 == 3) ? rand_span(32'd6553600) : '0;
                M_EXTREME:   v = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
                M_SMALL:     v = (e % 4 == 3) ? rand_span(32'd6553600) : rand_span(32'd131072);
                M_SPARSE:    v = (e % 4 != 3 && $urandom_range(0, 2) != 0) ? '0
                                                                          : rand_span(32'd131072);
                default:     v = $urandom;
            endcase
            send_request(make_write(j, 4'(e), v));
        end
    endtask

    // One vertex: mostly weights that split one whole, some overlong or rough ones
    task automatic send_vertex();
        int unsigned        n;
        int unsigned        r;
        int unsigned        wstyle;
        int unsigned        left;
        int unsigned        i;
        logic [15:0]        w;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        r = $urandom_range(0, 99);
        if (r < 55)
            n = $urandom_range(1, 4);
        else if (r < 88)
            n = $urandom_range(5, INFLUENCES);
        else
            n = $urandom_range(INFLUENCES + 1, INFLUENCES + 3);
        wstyle = $urandom_range(0, 99);
        // sometimes fall just short of a whole so the threshold edge is probed
        left = WEIGHT_ONE - (($urandom_range(0, 3) == 0) ? $urandom_range(0, 64) : 0);
        px   = rand_coord();
        py   = rand_coord();
        pz   = rand_coord();
        for (i = 0; i < n; i++)
        begin
            if (wstyle < 70)
            begin
                if (i == n - 1)
                    w = 16'(left);
                else
                begin
                    w = 16'($urandom_range(0, (2 * left) / (n - i)));
                    if (w > left)
                        w = 16'(left);
                end
                left -= w;
            end
            else if (wstyle < 85)
                w = 16'($urandom);
            else
                w = ($urandom_range(0, 2) == 0) ? 16'd0 : WEIGHT_ONE >> $urandom_range(0, 3);
            send_request(make_influence(pick_joint(), px, py, pz, w, i == n - 1));
        end
    endtask

    // Result side: runs of ready broken by stalls, with long stall-free stretches
    initial
    begin
        int unsigned run;
        int unsigned stall;
        forever
        begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 12);
            out_ready <= 1'b1;
            repeat (run) @(posedge clk);
            stall = pick_gap();
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        blend_request_t     rq;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic [15:0]        levels [PHASES];
        int unsigned        ph;
        int unsigned        mark;
        int unsigned        r;
        int unsigned        i;

        sb = new();
        foreach (loaded[j]) loaded[j] = '0;
        rst_n              <= 1'b0;
        in_valid           <= 1'b0;
        operation          <= OP_WRITE;
        joint              <= '0;
        element            <= '0;
        matrix_value       <= '0;
        pos_x              <= '0;
        pos_y              <= '0;
        pos_z              <= '0;
        weight             <= '0;
        last_influence     <= 1'b0;
        cfg_valid          <= 1'b0;
        visible_weight_min <= VIS_MIN_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Seed the palette: identity, translation only (never visible),
        // corner values (forces saturation) and a plain small matrix.
        load_matrix(6'd0,  M_IDENTITY);
        load_matrix(6'd63, M_TRANSLATE);
        load_matrix(6'd1,  M_EXTREME);
        load_matrix(6'd62, M_SMALL);

        // Directed vertices under the reset threshold
        px = 32'sd65536;
        py = 32'sd131072;
        pz = -32'sd196608;
        send_request(make_influence(6'd0,  px, py, pz, WEIGHT_ONE, 1'b1));   // unskinned
        send_request(make_influence(6'd63, px, py, pz, WEIGHT_ONE, 1'b1));   // zero upper block
        send_request(make_influence(6'd0,  px, py, pz, 16'd16384, 1'b0));    // even split
        send_request(make_influence(6'd62, px, py, pz, 16'd16384, 1'b1));
        send_request(make_influence(6'd0,  px, py, pz, 16'd0, 1'b0));        // zero weight
        send_request(make_influence(6'd0,  px, py, pz, WEIGHT_ONE, 1'b1));
        send_request(make_influence(6'd0,  px, py, pz, 16'hFFFF, 1'b1));     // weight above one
        send_request(make_influence(6'd0,  32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1,
                                    WEIGHT_ONE, 1'b1));
        send_request(make_influence(6'd1,  $urandom, $urandom, $urandom, WEIGHT_ONE, 1'b1));
        // more influences than slots: the surplus must be dropped
        for (i = 0; i < INFLUENCES + 2; i++)
            send_request(make_influence(6'd0, px, py, pz, 16'd4096, i == INFLUENCES + 1));
        // writes to elements past the matrix are ignored, last mark on a write too
        rq      = make_write(6'd0, 4'd13, 32'sh1234_5678);
        rq.last = 1'b1;
        send_request(rq);
        rq      = make_write(6'd0, 4'd15, 32'sh8000_0000);
        rq.last = 1'b1;
        send_request(rq);
        send_request(make_influence(6'd0,  px, py, pz, WEIGHT_ONE, 1'b1));
        send_request(make_influence(6'd62, px, py, pz, 16'd0, 1'b1));        // nothing added
        send_request(make_influence(6'd0,  px, py, pz, 16'd32767, 1'b1));    // just over threshold

        // Random phases, each under its own threshold, written while idle
        levels = '{16'd32768, 16'd0, 16'd32767, 16'($urandom_range(32600, 32768)),
                   16'($urandom_range(0, 32768)), VIS_MIN_RESET};
        for (ph = 0; ph < PHASES; ph++)
        begin
            drain_results(SETTLE);
            write_threshold(levels[ph]);
            mark = items_sent;
            while (items_sent - mark < PHASE_ITEMS)
            begin
                r = $urandom_range(0, 99);
                if (r < 2)
                    drain_results(0);
                if (r < 8)
                    load_matrix(6'($urandom_range(0, JOINTS - 1)),
                                matrix_style_t'($urandom_range(0, 5)));
                else if (r < 12)
                    send_request(make_write(6'($urandom_range(0, JOINTS - 1)),
                                            4'($urandom_range(0, 15)), $urandom));
                else
                    send_vertex();
            end
        end

        drain_results(SETTLE);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/svb_pkg.sv
rtl/svb_ctrl.sv
rtl/svb_datapath.sv
rtl/skinned_vertex_blend_top.sv
dv/skinned_vertex_blend_top_test.sv
